[hw/rtl/v3n_pkg.sv]
package v3n_pkg;

	// default geometry
	localparam int COMP_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

endpackage

[hw/rtl/v3n_lane.sv]
// One component: bit-serial restoring search for the largest q with
// q^2 * ssq <= rhs, one quotient bit per pipeline stage, MSB first.
// Keeps p = q^2*ssq and r = q*ssq so each trial is shifts and two adds.
module v3n_lane
	import v3n_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int PW = 2*COMP_WIDTH + 2*FRAC_BITS + 2,
	localparam int OW = FRAC_BITS + 2
) (
	input  logic                 clk,
	input  logic [PW-1:0]        ssq,
	input  logic [PW-1:0]        rhs,
	input  logic                 neg,
	output logic signed [OW-1:0] unit
);

	localparam int NS = FRAC_BITS + 2;

	logic [PW-1:0]      p_s   [NS];
	logic [PW-1:0]      r_s   [NS];
	logic [PW-1:0]      ssq_s [NS];
	logic [PW-1:0]      rhs_s [NS];
	logic [FRAC_BITS:0] q_s   [NS];
	logic               neg_s [NS];

	assign p_s[0]   = '0;
	assign r_s[0]   = '0;
	assign q_s[0]   = '0;
	assign ssq_s[0] = ssq;
	assign rhs_s[0] = rhs;
	assign neg_s[0] = neg;

	for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_bit
		localparam int K = FRAC_BITS - j;
		logic [PW-1:0] trial;
		logic          take;

		always_comb begin
			trial = p_s[j] + (r_s[j] << (K + 1)) + (ssq_s[j] << (2 * K));
			take  = (trial <= rhs_s[j]);
		end

		always_ff @(posedge clk) begin
			p_s[j+1]   <= take ? trial : p_s[j];
			r_s[j+1]   <= take ? (r_s[j] + (ssq_s[j] << K)) : r_s[j];
			q_s[j+1]   <= q_s[j] | ((FRAC_BITS+1)'(take) << K);
			ssq_s[j+1] <= ssq_s[j];
			rhs_s[j+1] <= rhs_s[j];
			neg_s[j+1] <= neg_s[j];
		end
	end

	logic [OW-1:0] mag_ext;
	assign mag_ext = {1'b0, q_s[NS-1]};
	assign unit    = neg_s[NS-1] ? -$signed(mag_ext) : $signed(mag_ext);

endmodule

[hw/rtl/vector3_normalize.sv]
// vector3_normalize: returns the unit vector of a signed 3-component input as
// signed Q1.FRAC_BITS, each component the exact quotient v*2^F/|v| truncated
// toward zero; a zero vector gives zeros with zero_length set. Fully pipelined:
// one transaction per clock, busy is never asserted, and the result appears on
// done after the abs, square and sum stages, the per-bit quotient search (one
// stage per result bit) and the output register. The receiver
// cannot stall: each result is shown for one cycle only and must be captured.
module vector3_normalize
	import v3n_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] vec_x,
	input  logic signed [COMP_WIDTH-1:0] vec_y,
	input  logic signed [COMP_WIDTH-1:0] vec_z,
	output logic                         done,
	output logic signed [FRAC_BITS+1:0]  unit_x,
	output logic signed [FRAC_BITS+1:0]  unit_y,
	output logic signed [FRAC_BITS+1:0]  unit_z,
	output logic                         zero_length
);

	localparam int W   = COMP_WIDTH;
	localparam int PW  = 2*W + 2*FRAC_BITS + 2;
	localparam int OW  = FRAC_BITS + 2;
	localparam int LS  = FRAC_BITS + 1;     // search stages
	localparam int LAT = LS + 4;            // abs, square, sum, search, output

	// never holds off a transaction
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// valid bits travel with the data
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// stage 1: magnitudes and signs; |-2^(W-1)| fits W unsigned bits
	logic [W-1:0] mag_s1 [3];
	logic [2:0]   neg_s1;
	logic signed [W-1:0] vin [3];
	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vin[i][W-1];
			mag_s1[i] <= vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
		end
	end

	// stage 2: squares
	logic [2*W-1:0] sq_s2 [3];
	logic [2:0]     neg_s2;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= (2*W)'(mag_s1[i]) * (2*W)'(mag_s1[i]);
		end
		neg_s2 <= neg_s1;
	end

	// stage 3: sum of squares, per-lane bound v^2 * 2^(2F), zero detect
	logic [PW-1:0] ssq_s3;
	logic [PW-1:0] rhs_s3 [3];
	logic [2:0]    neg_s3;
	logic          zero_s3;
	always_ff @(posedge clk) begin
		ssq_s3  <= PW'(sq_s2[0]) + PW'(sq_s2[1]) + PW'(sq_s2[2]);
		zero_s3 <= (sq_s2[0] == '0) && (sq_s2[1] == '0) && (sq_s2[2] == '0);
		for (int i = 0; i < 3; i++) begin
			rhs_s3[i] <= PW'(sq_s2[i]) << (2 * FRAC_BITS);
		end
		neg_s3 <= neg_s2;
	end

	// quotient search, one lane per component
	logic signed [OW-1:0] lane_q [3];
	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3n_lane #(
			.COMP_WIDTH (COMP_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.ssq  (ssq_s3),
			.rhs  (rhs_s3[i]),
			.neg  (neg_s3[i]),
			.unit (lane_q[i])
		);
	end

	// zero flag rides alongside the search stages
	logic [LS-1:0] zero_sd;
	always_ff @(posedge clk) begin
		zero_sd <= {zero_sd[LS-2:0], zero_s3};
	end

	// output register; a zero vector would otherwise search to all ones
	logic signed [OW-1:0] ux_q, uy_q, uz_q;
	logic                 zl_q;
	always_ff @(posedge clk) begin
		zl_q <= zero_sd[LS-1];
		ux_q <= zero_sd[LS-1] ? '0 : lane_q[0];
		uy_q <= zero_sd[LS-1] ? '0 : lane_q[1];
		uz_q <= zero_sd[LS-1] ? '0 : lane_q[2];
	end

	assign done        = vld_q[LAT-1];
	assign unit_x      = ux_q;
	assign unit_y      = uy_q;
	assign unit_z      = uz_q;
	assign zero_length = zl_q;

endmodule

[tb/sv/v3n_checker.sv]
module v3n_checker
	import v3n_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic signed [COMP_WIDTH_DEF-1:0] vec_x,
	input  logic signed [COMP_WIDTH_DEF-1:0] vec_y,
	input  logic signed [COMP_WIDTH_DEF-1:0] vec_z,
	input  logic                            done,
	input  logic signed [FRAC_BITS_DEF+1:0]  unit_x,
	input  logic signed [FRAC_BITS_DEF+1:0]  unit_y,
	input  logic signed [FRAC_BITS_DEF+1:0]  unit_z,
	input  logic                            zero_length,
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OW = FRAC_BITS_DEF + 2;

	typedef struct packed {
		logic signed [OW-1:0] ux;
		logic signed [OW-1:0] uy;
		logic signed [OW-1:0] uz;
		logic                 zl;
	} unit_vec_t;

	unit_vec_t unit_q[$];

	// largest q <= 2^F with q^2*ssq <= mag^2*2^(2F); all fits in 64 bits
	function automatic longint unsigned quot_mag(longint unsigned mag, longint unsigned ssq);
		longint unsigned lo, hi, mid, rhs;
		rhs = (mag * mag) << (2 * FRAC_BITS_DEF);
		lo = 0;
		hi = 64'd1 << FRAC_BITS_DEF;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (mid * mid * ssq <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic unit_vec_t normalize(logic signed [COMP_WIDTH_DEF-1:0] x,
			logic signed [COMP_WIDTH_DEF-1:0] y, logic signed [COMP_WIDTH_DEF-1:0] z);
		longint c[3];
		longint unsigned m[3];
		longint unsigned ssq, q;
		logic signed [OW-1:0] r[3];
		unit_vec_t e;
		c[0] = x;
		c[1] = y;
		c[2] = z;
		ssq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = c[i] < 0 ? -c[i] : c[i];
			ssq += m[i] * m[i];
		end
		if (ssq == 0) begin
			e = '0;
			e.zl = 1'b1;
			return e;
		end
		for (int i = 0; i < 3; i++) begin
			q = quot_mag(m[i], ssq);
			r[i] = c[i] < 0 ? -q[OW-1:0] : q[OW-1:0];
		end
		e.ux = r[0];
		e.uy = r[1];
		e.uz = r[2];
		e.zl = 1'b0;
		return e;
	endfunction

	assign pending = unit_q.size();

	always @(posedge clk or negedge arst_n) begin
		unit_vec_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				unit_q.push_back(normalize(vec_x, vec_y, vec_z));
			if (done) begin
				if (unit_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %0d %0d %0d zl=%0b", unit_x, unit_y,
							unit_z, zero_length);
					fail_count <= fail_count + 1;
				end else begin
					e = unit_q.pop_front();
					if (e.ux !== unit_x || e.uy !== unit_y || e.uz !== unit_z ||
							e.zl !== zero_length) begin
						if (fail_count < 10)
							$display("mismatch exp %0d %0d %0d zl=%0b got %0d %0d %0d zl=%0b",
								e.ux, e.uy, e.uz, e.zl, unit_x, unit_y, unit_z, zero_length);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[tb/sv/tb_vector3_normalize.sv]
module tb_vector3_normalize;
	import v3n_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COMP_WIDTH_DEF;
	localparam int LATENCY = FRAC_BITS_DEF + 5;
	localparam int IDLE_LIMIT = 2000;	// cycles with no transaction before giving up

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic done, zero_length;
	logic signed [FRAC_BITS_DEF+1:0] unit_x, unit_y, unit_z;
	int fail_count, pending;
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vector3_normalize u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.zero_length(zero_length)
	);

	v3n_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.zero_length(zero_length), .fail_count(fail_count), .pending(pending)
	);

	// watchdog: any accepted transaction on either side resets the count
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// hold start high; returns after the edge that accepts the transaction
	task automatic send_vec(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [CW-1:0] z);
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		do @(posedge clk); while (busy);
	endtask

	// component value: full range, tiny, near extremes, or zero
	function automatic logic signed [CW-1:0] rand_comp();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2:    return $signed(16'($urandom_range(0, 6)) - 16'd3);
			3:       return $urandom_range(0, 1) ? 16'(16'sh7FFF - $urandom_range(0, 3))
				: 16'(16'sh8000 + $urandom_range(0, 3));
			4:       return $signed(16'($urandom_range(0, 255)) - 16'd128);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic signed [CW-1:0] dir_v[20][3];
		int burst;

		// directed: zero vector, axis extremes, full-scale diagonals, tiny and mixed vectors
		dir_v = '{
			'{16'sd0, 16'sd0, 16'sd0},
			'{16'sh7FFF, 16'sd0, 16'sd0}, '{16'sh8000, 16'sd0, 16'sd0},
			'{16'sd0, 16'sh7FFF, 16'sd0}, '{16'sd0, 16'sh8000, 16'sd0},
			'{16'sd0, 16'sd0, 16'sh7FFF}, '{16'sd0, 16'sd0, 16'sh8000},
			'{16'sd1, 16'sd0, 16'sd0}, '{16'sd0, -16'sd1, 16'sd0},
			'{16'sd0, 16'sd0, -16'sd1},
			'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '{16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh8000, 16'sh7FFF, 16'sh8000}, '{16'sd1, 16'sd1, 16'sd1},
			'{-16'sd1, -16'sd1, -16'sd1}, '{16'sd3, 16'sd4, 16'sd0},
			'{-16'sd2, 16'sd3, 16'sd6}, '{16'sh8000, 16'sd1, 16'sd0},
			'{16'sh5555, 16'shAAAA, 16'sh0F0F}, '{16'sd0, 16'sd0, 16'sd0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_v[i])
			send_vec(dir_v[i][0], dir_v[i][1], dir_v[i][2]);

		// random bursts with random gaps; some long runs with no gap at all
		for (int n = 0; n < 1050; ) begin
			burst = $urandom_range(1, $urandom_range(0, 3) == 0 ? 60 : 8);
			for (int k = 0; k < burst; k++, n++)
				send_vec(rand_comp(), rand_comp(), rand_comp());
			start <= 1'b0;
			repeat ($urandom_range(1, 2) == 1 ? $urandom_range(1, 3)
				: $urandom_range(0, 25)) @(posedge clk);
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
